@@ rtl/double_ended_queue_macros.svh @@
// Assertion macros shared by the deque checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deque check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deque check failed");

`endif

@@ rtl/deq_pkg.sv @@
// Shared types and constants of the double-ended queue.
// No dependencies; imported by every module of the block but deq_ram.
package deq_pkg;

	localparam int DEQ_DEPTH = 16;
	localparam int DATA_W    = 32;
	localparam int MODE_W    = 3;
	localparam int STATUS_W  = 2;

	// operation codes
	localparam logic [MODE_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [MODE_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [MODE_W-1:0] OP_READ_FRONT = 3'd4;
	localparam logic [MODE_W-1:0] OP_READ_BACK  = 3'd5;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic {
		CS_IDLE,
		CS_FETCH
	} deq_state_t;

	// controller commands to the datapath
	typedef struct packed {
		logic accept;
		logic load_out;
	} deq_cmd_t;

endpackage

@@ rtl/double_ended_queue.sv @@
// Top level of the bounded double-ended queue of signed 32-bit words.
// Depends on deq_pkg, deq_ctrl, deq_dp (and deq_ram below it).
//
//   channel  direction  handshake            payload
//   in       receive    in_valid / in_stall   mode, push_value
//   out      send       out_valid / out_stall status, read_value, occupancy
//
// One operation is taken per cycle unless out stalls; the registered RAM read
// and the fetch-stage registers load at the transfer edge, and the output
// register loads from them when the fetch stage moves up.
// Reset clears the front pointer and count; entries need no clearing pass.
// A stall on out holds the output register, then the fetch stage, then in.
module double_ended_queue #(
	parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [deq_pkg::MODE_W-1:0]         mode,
	input  logic signed [deq_pkg::DATA_W-1:0]  push_value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [deq_pkg::STATUS_W-1:0]       status,
	output logic signed [deq_pkg::DATA_W-1:0]  read_value,
	output logic [$clog2(DEPTH+1)-1:0]         occupancy
);
	import deq_pkg::*;

	deq_cmd_t cmd;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	deq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.mode       (mode),
		.push_value (push_value),
		.status     (status),
		.read_value (read_value),
		.occupancy  (occupancy)
	);

endmodule

@@ rtl/deq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/deq_ctrl.sv @@
// Deque controller: tracks the fetch stage and the output register.
// Depends on deq_pkg.
module deq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output deq_pkg::deq_cmd_t cmd
);
	import deq_pkg::*;

	deq_state_t state_q, state_d;
	logic       out_valid_q;
	logic       load_out;
	logic       accept;

	// outputs
	always_comb begin
		load_out = (state_q == CS_FETCH) && (!out_valid_q || !out_stall);
		in_stall = (state_q == CS_FETCH) && !load_out;
		accept   = in_valid && !in_stall;
		cmd.accept   = accept;
		cmd.load_out = load_out;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE: begin
				if (accept) begin
					state_d = CS_FETCH;
				end
			end
			CS_FETCH: begin
				if (load_out && !accept) begin
					state_d = CS_IDLE;
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			// hold while stalled, refill when the fetch stage moves up
			out_valid_q <= load_out || (out_valid_q && out_stall);
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/deq_dp.sv @@
// Deque datapath: front pointer, count, entry RAM and result registers.
// Depends on deq_pkg and deq_ram.
module deq_dp #(
	parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  deq_pkg::deq_cmd_t                  cmd,
	input  logic [deq_pkg::MODE_W-1:0]         mode,
	input  logic signed [deq_pkg::DATA_W-1:0]  push_value,
	output logic [deq_pkg::STATUS_W-1:0]       status,
	output logic signed [deq_pkg::DATA_W-1:0]  read_value,
	output logic [$clog2(DEPTH+1)-1:0]         occupancy
);
	import deq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	logic [AW-1:0]       front_q, front_d;
	logic [CW-1:0]       count_q, count_d;
	logic [AW-1:0]       front_dec, front_inc;
	logic [SW-1:0]       tail_sum, last_sum;
	logic [SW-1:0]       tail_wrap, last_wrap;
	logic                is_full, is_empty;

	logic                ram_we, ram_re;
	logic [AW-1:0]       ram_addr;
	logic [DATA_W-1:0]   ram_rdata;

	logic [STATUS_W-1:0] status_d;
	logic                rdsel_d;

	logic [STATUS_W-1:0] status_s1;
	logic                rdsel_s1;
	logic [CW-1:0]       occ_s1;

	logic [STATUS_W-1:0] status_q;
	logic [DATA_W-1:0]   read_value_q;
	logic [CW-1:0]       occupancy_q;

	always_comb begin
		is_full   = (count_q == CW'(DEPTH));
		is_empty  = (count_q == '0);
		front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
		front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
		// sums stay below twice the depth, so one subtract wraps them
		tail_sum  = SW'(front_q) + SW'(count_q);
		last_sum  = tail_sum - 1'b1;
		tail_wrap = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
		last_wrap = (last_sum >= SW'(DEPTH)) ? last_sum - SW'(DEPTH) : last_sum;
	end

	always_comb begin
		front_d  = front_q;
		count_d  = count_q;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		ram_addr = front_q;
		status_d = ST_OK;
		rdsel_d  = 1'b0;
		unique case (mode)
			OP_PUSH_FRONT: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					front_d  = front_dec;
					count_d  = count_q + 1'b1;
					ram_addr = front_dec;
					ram_we   = 1'b1;
				end
			end
			OP_PUSH_BACK: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					count_d  = count_q + 1'b1;
					ram_addr = tail_wrap[AW-1:0];
					ram_we   = 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					front_d  = front_inc;
					count_d  = count_q - 1'b1;
					ram_re   = 1'b1;
					rdsel_d  = 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					count_d  = count_q - 1'b1;
					ram_addr = last_wrap[AW-1:0];
					ram_re   = 1'b1;
					rdsel_d  = 1'b1;
				end
			end
			OP_READ_FRONT: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					ram_re  = 1'b1;
					rdsel_d = 1'b1;
				end
			end
			OP_READ_BACK: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					ram_addr = last_wrap[AW-1:0];
					ram_re   = 1'b1;
					rdsel_d  = 1'b1;
				end
			end
			default: begin
				// unused codes: no operation
			end
		endcase
	end

	deq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.accept && ram_we),
		.waddr (ram_addr),
		.wdata ($unsigned(push_value)),
		.re    (cmd.accept && ram_re),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (cmd.accept) begin
			front_q <= front_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			status_s1 <= status_d;
			rdsel_s1  <= rdsel_d;
			occ_s1    <= count_d;
		end
		if (cmd.load_out) begin
			status_q     <= status_s1;
			read_value_q <= rdsel_s1 ? ram_rdata : '0;
			occupancy_q  <= occ_s1;
		end
	end

	assign status     = status_q;
	assign read_value = $signed(read_value_q);
	assign occupancy  = occupancy_q;

endmodule

@@ rtl/deq_checker.sv @@
// Port-level checks of the double-ended queue, bound to the top level.
// Depends on deq_pkg and double_ended_queue_macros.svh.
`include "double_ended_queue_macros.svh"

module deq_checker #(
	parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [deq_pkg::STATUS_W-1:0]       status,
	input logic signed [deq_pkg::DATA_W-1:0]  read_value,
	input logic [$clog2(DEPTH+1)-1:0]         occupancy
);
	import deq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	`DEQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(read_value) && $stable(occupancy))
	`DEQ_ASSERT_IMPLY(a_occ_range, clk, arst_n, out_valid, occupancy <= CW'(DEPTH))
	`DEQ_ASSERT_IMPLY(a_full_result, clk, arst_n, out_valid && status == ST_FULL, occupancy == CW'(DEPTH) && read_value == '0)
	`DEQ_ASSERT_IMPLY(a_empty_result, clk, arst_n, out_valid && status == ST_EMPTY, occupancy == '0 && read_value == '0)

endmodule

bind double_ended_queue deq_checker #(.DEPTH(DEPTH)) u_chk (.*);

@@ verif/tb_double_ended_queue.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for double_ended_queue: directed corner cases, a full-queue run
// under output back-pressure, and random operation mixes under several idle and stall
// patterns. Depends on deq_pkg and the double_ended_queue RTL.
module tb_double_ended_queue;
	import deq_pkg::*;

	localparam int OCC_W = $clog2(DEQ_DEPTH + 1);
	localparam int CYCLE_LIMIT = 100000;
	// modes the block treats as no-ops
	localparam logic [MODE_W-1:0] OP_UNUSED_6 = 3'd6;
	localparam logic [MODE_W-1:0] OP_UNUSED_7 = 3'd7;
	localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
	localparam logic [DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] WORD_ONES = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DATA_W-1:0]   read_value;
		logic [OCC_W-1:0]    occupancy;
	} deq_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [MODE_W-1:0] mode = '0;
	logic signed [DATA_W-1:0] push_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic signed [DATA_W-1:0] read_value;
	logic [OCC_W-1:0] occupancy;

	// shadow copy of the deque contents
	logic [DATA_W-1:0] shadow_words [DEQ_DEPTH];
	int shadow_front = 0;
	int shadow_count = 0;

	deq_result_t awaited_results [$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int holdoff_left = 0;
	int error_count = 0;
	int ops_sent = 0;
	int results_checked = 0;
	int dropped_pushes = 0;
	int empty_accesses = 0;
	int cycle_count = 0;

	double_ended_queue DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.push_value(push_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.read_value(read_value),
		.occupancy(occupancy)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t timeout after %0d cycles", $time, cycle_count);
			$display("tb_double_ended_queue NOT OK");
			$finish;
		end
	end

	// Receiver: a long hold-off wins over the random stall pattern.
	always @(posedge clk) begin
		if (holdoff_left > 0) begin
			out_stall <= 1'b1;
			holdoff_left = holdoff_left - 1;
		end else begin
			out_stall <= (recv_stall_pct > 0) && ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Apply one operation to the shadow deque and return what the block should report.
	function automatic deq_result_t deque_apply(input logic [MODE_W-1:0] m,
			input logic [DATA_W-1:0] v);
		deq_result_t r;
		int idx;
		r.status = ST_OK;
		r.read_value = '0;
		case (m)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (shadow_count >= DEQ_DEPTH) begin
					r.status = ST_FULL;
					dropped_pushes++;
				end else begin
					if (m == OP_PUSH_FRONT) begin
						shadow_front = (shadow_front + DEQ_DEPTH - 1) % DEQ_DEPTH;
						idx = shadow_front;
					end else begin
						idx = (shadow_front + shadow_count) % DEQ_DEPTH;
					end
					shadow_words[idx] = v;
					shadow_count++;
				end
			end
			OP_POP_FRONT, OP_POP_BACK, OP_READ_FRONT, OP_READ_BACK: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
					empty_accesses++;
				end else begin
					if (m == OP_POP_FRONT || m == OP_READ_FRONT)
						idx = shadow_front;
					else
						idx = (shadow_front + shadow_count - 1) % DEQ_DEPTH;
					r.read_value = shadow_words[idx];
					if (m == OP_POP_FRONT) begin
						shadow_front = (shadow_front + 1) % DEQ_DEPTH;
						shadow_count--;
					end else if (m == OP_POP_BACK) begin
						shadow_count--;
					end
				end
			end
			default: ;
		endcase
		r.occupancy = shadow_count[OCC_W-1:0];
		return r;
	endfunction

	// Offer one operation, hold it until the transfer, then record its expected result.
	task automatic send_op(input logic [MODE_W-1:0] m, input logic [DATA_W-1:0] v);
		if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			mode <= MODE_W'($urandom);
			push_value <= $urandom;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		mode <= m;
		push_value <= v;
		do @(posedge clk); while (in_stall !== 1'b0);
		awaited_results.push_back(deque_apply(m, v));
		ops_sent++;
	endtask

	always @(posedge clk) begin
		deq_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (awaited_results.size() == 0) begin
				error_count++;
				$display("%0t unexpected result: status %0d read_value %h occupancy %0d",
					$time, status, read_value, occupancy);
			end else begin
				want = awaited_results.pop_front();
				results_checked++;
				if (status !== want.status) begin
					error_count++;
					$display("%0t status: expected %0d, got %0d", $time, want.status, status);
				end
				if (read_value !== want.read_value) begin
					error_count++;
					$display("%0t read_value: expected %h, got %h", $time,
						want.read_value, read_value);
				end
				if (occupancy !== want.occupancy) begin
					error_count++;
					$display("%0t occupancy: expected %0d, got %0d", $time,
						want.occupancy, occupancy);
				end
			end
		end
	end

	function automatic logic [DATA_W-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return '0;
			3: return WORD_ONES;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [MODE_W-1:0] pick_mode(input int push_weight);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return (r == 0) ? OP_UNUSED_6 : OP_UNUSED_7;
		if ($urandom_range(0, 99) < push_weight)
			return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
		case ($urandom_range(0, 3))
			0: return OP_POP_FRONT;
			1: return OP_POP_BACK;
			2: return OP_READ_FRONT;
			default: return OP_READ_BACK;
		endcase
	endfunction

	task automatic test_corner_cases();
		send_op(OP_POP_FRONT, WORD_ONES);
		send_op(OP_POP_BACK, WORD_ONES);
		send_op(OP_READ_FRONT, '0);
		send_op(OP_READ_BACK, '0);
		send_op(OP_UNUSED_6, WORD_ONES);
		send_op(OP_UNUSED_7, WORD_MIN);
		// push front on an empty deque wraps the front pointer below zero
		send_op(OP_PUSH_FRONT, WORD_MIN);
		send_op(OP_PUSH_BACK, WORD_MAX);
		send_op(OP_READ_FRONT, '0);
		send_op(OP_READ_BACK, '0);
		send_op(OP_PUSH_FRONT, '0);
		send_op(OP_PUSH_BACK, WORD_ONES);
		send_op(OP_UNUSED_7, WORD_ONES);
		send_op(OP_POP_BACK, '0);
		send_op(OP_POP_FRONT, '0);
		send_op(OP_POP_FRONT, '0);
		send_op(OP_POP_BACK, '0);
		// front pointer stays where the last pop left it
		send_op(OP_READ_BACK, '0);
		send_op(OP_PUSH_BACK, 32'h5555_5555);
		send_op(OP_PUSH_FRONT, 32'hAAAA_AAAA);
		send_op(OP_READ_FRONT, '0);
		send_op(OP_POP_BACK, '0);
		send_op(OP_POP_BACK, '0);
	endtask

	// Hold off the output long enough that the pipeline backs up into the input,
	// while pushes run the deque to full and beyond.
	task automatic test_full_under_holdoff();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		holdoff_left = 60;
		repeat (DEQ_DEPTH + 8)
			send_op($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_word());
		send_op(OP_READ_FRONT, '0);
		send_op(OP_READ_BACK, '0);
		for (int i = 0; i < DEQ_DEPTH + 4; i++)
			send_op(i[0] ? OP_POP_BACK : OP_POP_FRONT, '0);
	endtask

	// Alternate fill-biased and drain-biased stretches so both full and empty recur.
	task automatic run_random_ops(input int n);
		int push_weight;
		push_weight = 70;
		for (int i = 0; i < n; i++) begin
			if (i % 32 == 31)
				push_weight = 100 - push_weight;
			send_op(pick_mode(push_weight), pick_word());
		end
	endtask

	task automatic test_random_no_idling();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_random_ops(160);
	endtask

	task automatic test_random_sender_idle();
		send_idle_pct = 60;
		recv_stall_pct = 0;
		run_random_ops(160);
	endtask

	task automatic test_random_receiver_stall();
		send_idle_pct = 0;
		recv_stall_pct = 60;
		run_random_ops(160);
	endtask

	task automatic test_random_both_idle();
		send_idle_pct = 17;
		recv_stall_pct = 17;
		run_random_ops(160);
	endtask

	initial begin
		for (int i = 0; i < DEQ_DEPTH; i++)
			shadow_words[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_cases();
		test_full_under_holdoff();
		test_random_no_idling();
		test_random_sender_idle();
		test_random_receiver_stall();
		test_random_both_idle();

		// drain: drop valid, release the output and let the pipeline empty
		send_idle_pct = 0;
		recv_stall_pct = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Ran %0d deque operations, %0d results compared field by field.",
			ops_sent, results_checked);
		$display("Dropped pushes on a full deque: %0d, empty pops/reads: %0d.",
			dropped_pushes, empty_accesses);
		if (error_count == 0)
			$display("tb_double_ended_queue OK");
		else
			$display("tb_double_ended_queue NOT OK");
		$finish;
	end

endmodule
